/* design/block_transposition_cipher_assert.svh */
// Assertion macros for the block transposition cipher checker.
`ifndef BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH
`define BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/btc_pkg.sv */
// Types, constants and helper functions of the block transposition cipher.
package btc_pkg;

  localparam int MAX_BLOCK_DEF = 9;
  // Counts of up to 31 bytes, more than the widest block the design supports.
  localparam int CNT_W         = 5;
  localparam int PERM_ENTRIES  = 9;
  localparam int PERM_ENTRY_W  = 4;
  localparam int PERM_W        = PERM_ENTRIES * PERM_ENTRY_W;
  localparam int BSIZE_W       = 4;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 5;
  localparam int REG_IDX_LSB   = 3;

  localparam logic [7:0]         PAD_CHAR       = 8'h20;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 4'd9;
  localparam logic [PERM_W-1:0]  PERM_RST       = 36'h876543210;

  typedef enum logic [ADDR_W-REG_IDX_LSB-1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_PERMUTATION  = 2'd1,
    REG_DECRYPT_MODE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
  } rsp_t;

  // One completed block waiting in the buffer memory.
  typedef struct packed {
    logic             slot;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] size;
    logic             eom;
  } blk_desc_t;

  function automatic logic [PERM_ENTRY_W-1:0] perm_entry(input logic [PERM_W-1:0] perm,
                                                         input int unsigned idx);
    if (idx >= PERM_ENTRIES) begin
      return '0;
    end
    return perm[idx*PERM_ENTRY_W +: PERM_ENTRY_W];
  endfunction

  // Block size as used: zero counts as one, and it is capped at the largest block.
  function automatic logic [CNT_W-1:0] eff_size(input logic [BSIZE_W-1:0] bs,
                                                input int unsigned max_block);
    if (bs == '0) begin
      return CNT_W'(1);
    end
    if (int'(bs) > max_block) begin
      return CNT_W'(max_block);
    end
    return CNT_W'(bs);
  endfunction

endpackage

/* design/btc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module btc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/btc_front.sv */
// Front end: takes message bytes, writes them into the block buffer and closes blocks.
module btc_front import btc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [BSIZE_W-1:0]             block_size,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  req_t                           req,
  input  logic                           full,
  output logic                           push,
  output blk_desc_t                      push_desc,
  output logic                           ram_we,
  output logic [$clog2(MAX_BLOCK):0]     ram_waddr,
  output logic [7:0]                     ram_wdata
);

  localparam int POS_W = $clog2(MAX_BLOCK);

  logic             fill;
  logic [CNT_W-1:0] fill_cnt;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] size_eff;
  logic             slot;
  logic             accept;
  logic             done;

  assign size_eff  = eff_size(block_size, MAX_BLOCK);
  // The slot being filled is free whenever fewer than two blocks are queued.
  assign req_ready = !full;
  assign accept    = req_valid && req_ready;
  assign fill_next = fill_cnt + CNT_W'(1);
  assign done      = (fill_next >= size_eff) || req.end_of_message;
  assign fill      = accept && !done;

  assign ram_we    = accept;
  assign ram_waddr = {slot, fill_cnt[POS_W-1:0]};
  assign ram_wdata = req.char_in;

  assign push      = accept && done;
  assign push_desc = '{slot: slot, fill: fill_next, size: size_eff,
                       eom: req.end_of_message};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      slot     <= 1'b0;
    end else if (fill) begin
      fill_cnt <= fill_next;
    end else if (push) begin
      fill_cnt <= '0;
      slot     <= ~slot;
    end
  end

endmodule

/* design/btc_queue.sv */
// Two-entry queue of completed block descriptors between front and back end.
module btc_queue import btc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  blk_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output blk_desc_t head
);

  blk_desc_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/btc_back.sv */
// Back end: walks the output positions of the head block and emits the rearranged bytes.
module btc_back import btc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [PERM_W-1:0]          permutation,
  input  logic                       decrypt_mode,
  input  logic                       head_valid,
  input  blk_desc_t                  head,
  output logic                       pop,
  output logic                       ram_re,
  output logic [$clog2(MAX_BLOCK):0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output rsp_t                       rsp
);

  localparam int POS_W = $clog2(MAX_BLOCK);

  logic [POS_W-1:0] pos;
  logic             s1_valid;
  logic             s1_pad;
  logic             s1_last;
  logic             out_free;
  logic             s1_free;
  logic             issue;
  logic             last_pos;
  logic [POS_W-1:0] src;
  logic             hit;
  logic             pad;

  assign out_free = !rsp_valid || rsp_ready;
  assign s1_free  = !s1_valid || out_free;
  assign issue    = head_valid && s1_free;
  assign last_pos = (CNT_W'(pos) == head.size - CNT_W'(1));

  // Source position for the current output position.
  always_comb begin
    logic [PERM_ENTRY_W-1:0] ent;
    src = '0;
    hit = 1'b0;
    if (decrypt_mode) begin
      // The highest entry that targets this position wins.
      for (int i = 0; i < MAX_BLOCK; i++) begin
        ent = perm_entry(permutation, i);
        if ((CNT_W'(i) < head.size) && (CNT_W'(ent) == CNT_W'(pos))) begin
          src = POS_W'(i);
          hit = 1'b1;
        end
      end
    end else begin
      ent = perm_entry(permutation, int'(pos));
      if (CNT_W'(ent) < head.size) begin
        src = ent[POS_W-1:0];
        hit = 1'b1;
      end
    end
  end

  // Unmapped positions and positions past the bytes received become spaces.
  assign pad       = !hit || (CNT_W'(src) >= head.fill);
  assign ram_re    = issue;
  assign ram_raddr = {head.slot, src};
  assign pop       = issue && last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (issue) begin
        pos <= last_pos ? '0 : pos + POS_W'(1);
      end
      if (s1_free) begin
        s1_valid <= issue;
      end
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pad  <= pad;
      s1_last <= head.eom && last_pos;
    end
    if (out_free && s1_valid) begin
      rsp.char_out <= s1_pad ? PAD_CHAR : ram_rdata;
      rsp.last_out <= s1_last;
    end
  end

endmodule

/* design/block_transposition_cipher.sv */
// Top level of the block transposition cipher: configuration registers and the datapath.
//
// The block takes one message byte per request and gathers the bytes into blocks of the
// configured size (zero counts as one, and sizes above MAX_BLOCK count as MAX_BLOCK).
// When a block is full, or when the byte marked as the end of the message arrives, the
// block is sent out as one response per position, rearranged by the permutation: in
// encrypt mode position i takes stored byte perm[i], in decrypt mode position perm[i]
// takes stored byte i, the highest such entry winning. Positions with no valid source,
// and positions past the bytes received in a short final block, carry a space (0x20).
// The final response of a message carries last_out. Bytes are held in a buffer memory
// of two slots: the front end fills one slot while the back end reads the other, so a
// byte is taken in every cycle while a slot is free, and the back end emits one response
// per cycle while responses are taken, limited by the single read port of that memory.
// The first response of a block passes the queue, the read stage and the output register
// after the request that closes it. A short final block sends out more responses than
// it took in, so input stalls for the difference when both slots are taken. Configuration
// is written over the APB-style port with 64-bit data: block_size at 0x00, permutation
// at 0x08, decrypt_mode at 0x10; change it only while no block is waiting or being sent.
module block_transposition_cipher import btc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);

  localparam int POS_W     = $clog2(MAX_BLOCK);
  localparam int RAM_DEPTH = 2 * (2 ** POS_W);

  logic [BSIZE_W-1:0] block_size;
  logic [PERM_W-1:0]  permutation;
  logic               decrypt_mode;
  logic               cfg_wr;
  reg_idx_t           reg_idx;

  logic               full;
  logic               push;
  blk_desc_t          push_desc;
  logic               pop;
  logic               head_valid;
  blk_desc_t          head;
  logic               ram_we;
  logic [POS_W:0]     ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [POS_W:0]     ram_raddr;
  logic [7:0]         ram_rdata;

  // Configuration registers. The port never waits, so a write lands on the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BLOCK_SIZE_RST;
      permutation  <= PERM_RST;
      decrypt_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BLOCK_SIZE:   block_size   <= pwdata[BSIZE_W-1:0];
        REG_PERMUTATION:  permutation  <= pwdata[PERM_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_SIZE:   prdata = DATA_W'(block_size);
      REG_PERMUTATION:  prdata = DATA_W'(permutation);
      REG_DECRYPT_MODE: prdata = DATA_W'(decrypt_mode);
      default:          prdata = '0;
    endcase
  end

  // Front end: collects bytes into the free slot and queues each finished block.
  btc_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk        (clk),
    .rst        (rst),
    .block_size (block_size),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .full       (full),
    .push       (push),
    .push_desc  (push_desc),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // Queue of finished blocks; its depth matches the two buffer slots.
  btc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Buffer memory: slot in the top address bit, byte position below it.
  btc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_buf (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .re      (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Back end: one output position per cycle while responses are taken, through a read stage and the output register.
  btc_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk          (clk),
    .rst          (rst),
    .permutation  (permutation),
    .decrypt_mode (decrypt_mode),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp)
  );

endmodule

/* design/btc_checker.sv */
// Port-level assertions for the block transposition cipher, bound to its top level.
`include "block_transposition_cipher_assert.svh"

module btc_checker import btc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              req_valid,
  input logic              req_ready,
  input req_t              req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input rsp_t              rsp
);

  logic               req_stall;
  logic               rsp_stall;
  logic               size_sel;
  logic               size_wr;
  logic [BSIZE_W-1:0] wr_size;
  logic [BSIZE_W-1:0] rd_size;

  assign req_stall = req_valid && !req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign size_sel  = (paddr[ADDR_W-1:REG_IDX_LSB] == REG_BLOCK_SIZE);
  assign size_wr   = psel && penable && pwrite && pready && size_sel;
  assign wr_size   = pwdata[BSIZE_W-1:0];
  assign rd_size   = prdata[BSIZE_W-1:0];

  // Reset empties the output register and both buffer slots.
  `BTC_ASSERT_ALWAYS(a_rst_rsp_idle, rst |=> !rsp_valid, "response valid after reset")
  `BTC_ASSERT_ALWAYS(a_rst_req_ready, rst |=> req_ready, "request not ready after reset")

  // A waiting request keeps its payload until it is taken.
  `BTC_ASSERT(a_req_hold, req_stall |=> req_valid && $stable(req), "request not held")

  // A stalled response holds its payload.
  `BTC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp), "response not held")

  // A block size write reads back on the following cycle.
  `BTC_ASSERT(a_size_readback, size_wr ##1 size_sel |-> rd_size == $past(wr_size), "size readback")

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (.*);
